// ===== hdl/pdsel_pkg.sv =====
// Shared types and constants for the power offer selector.
package pdsel_pkg;

    // Field widths
    localparam int WORD_W   = 32;
    localparam int UNITS_W  = 10;
    localparam int MV_W     = 16;
    localparam int MA_W     = 14;
    localparam int POWER_W  = 29;
    localparam int LIMIT_W  = 20;
    localparam int COUNT_W  = 3;
    localparam int DIV_CNT_W = 5;
    localparam int DIV_STEPS = POWER_W;

    // Offer word decoding
    localparam logic [1:0] TYPE_BATTERY = 2'b01;
    localparam logic [MV_W-1:0]    MV_PER_UNIT      = 16'd50;
    localparam logic [MA_W-1:0]    MA_PER_UNIT      = 14'd10;
    localparam logic [POWER_W-1:0] BATT_UW_PER_UNIT = 29'd250000;
    localparam logic [LIMIT_W-1:0] LIMIT_MAX        = 20'hFFFFF;
    localparam logic [MV_W-1:0]    CAP_RESET        = 16'hFFFF;

    // Result status codes
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_NO_PDO  = 1'b1;

    typedef struct packed {
        logic [WORD_W-1:0] offer_word;
        logic              last_offer;
    } offer_in_t;

    typedef struct packed {
        logic               status;
        logic [WORD_W-1:0]  request_word;
        logic [LIMIT_W-1:0] current_limit_ma;
        logic [MV_W-1:0]    voltage_mv;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MULT,
        ST_CMP,
        ST_DIV_SET,
        ST_DIV,
        ST_FINISH
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic mult;
        logic compare;
        logic div_init;
        logic div_step;
        logic finish;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic last;
        logic div_needed;
        logic div_done;
        logic out_free;
    } status_t;

endpackage

// ===== hdl/pdsel_datapath.sv =====
// Datapath: offer decode, power product, best-offer tracking, serial divider, result register.
module pdsel_datapath #(
    parameter int MAX_OFFERS = 7
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  pdsel_pkg::cmd_t     cmd,
    output pdsel_pkg::status_t  stat,
    input  pdsel_pkg::offer_in_t in_data,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_wdata,
    output logic                m_valid,
    input  logic                m_ready,
    output pdsel_pkg::result_t  m_data
);

    localparam logic [pdsel_pkg::COUNT_W-1:0] MAX_CNT = pdsel_pkg::COUNT_W'(MAX_OFFERS);

    // Captured offer
    logic [pdsel_pkg::UNITS_W-1:0] units_reg;
    logic [pdsel_pkg::MV_W-1:0]    mv_reg;
    logic [pdsel_pkg::MA_W-1:0]    ma_reg;
    logic                          battery_reg;
    logic                          last_reg;
    logic [pdsel_pkg::POWER_W-1:0] power_reg;

    // List state
    logic [pdsel_pkg::COUNT_W-1:0] offer_count_reg;
    logic [pdsel_pkg::COUNT_W-1:0] best_position_reg;
    logic                          best_found_reg;
    logic [pdsel_pkg::POWER_W-1:0] best_power_reg;
    logic [pdsel_pkg::MV_W-1:0]    best_voltage_reg;
    logic [pdsel_pkg::UNITS_W-1:0] best_units_reg;
    logic                          best_is_battery_reg;

    logic [pdsel_pkg::MV_W-1:0]    cap_reg;

    // Divider
    logic [pdsel_pkg::POWER_W-1:0]   quo_reg;
    logic [pdsel_pkg::MV_W-1:0]      rem_reg;
    logic [pdsel_pkg::DIV_CNT_W-1:0] div_cnt_reg;

    logic               out_valid_reg;
    pdsel_pkg::result_t out_reg;

    logic [pdsel_pkg::POWER_W-1:0] prod;
    logic [pdsel_pkg::POWER_W-1:0] batt_power;
    logic                          take;
    logic [pdsel_pkg::MV_W:0]      trial;
    logic [pdsel_pkg::MV_W:0]      shifted;
    logic [pdsel_pkg::LIMIT_W-1:0] limit;
    logic [2:0]                    index1;
    pdsel_pkg::result_t            result_next;

    // Power of the captured offer
    assign prod       = pdsel_pkg::POWER_W'(ma_reg) * pdsel_pkg::POWER_W'(mv_reg);
    assign batt_power = pdsel_pkg::POWER_W'(units_reg) * pdsel_pkg::BATT_UW_PER_UNIT;

    // Offer wins on strictly greater power within the cap, while slots remain
    assign take = (offer_count_reg < MAX_CNT) && (power_reg > best_power_reg)
                  && (mv_reg <= cap_reg);

    // One restoring division step
    assign shifted = {rem_reg, quo_reg[pdsel_pkg::POWER_W-1]};
    assign trial   = shifted - {1'b0, best_voltage_reg};

    // Result assembly
    always_comb begin
        index1 = best_position_reg + 3'd1;
        if (best_is_battery_reg) begin
            if (best_voltage_reg == '0) begin
                limit = pdsel_pkg::LIMIT_MAX;
            end else if (|quo_reg[pdsel_pkg::POWER_W-1:pdsel_pkg::LIMIT_W]) begin
                limit = pdsel_pkg::LIMIT_MAX;
            end else begin
                limit = quo_reg[pdsel_pkg::LIMIT_W-1:0];
            end
        end else begin
            limit = pdsel_pkg::LIMIT_W'(pdsel_pkg::MA_W'(best_units_reg) * pdsel_pkg::MA_PER_UNIT);
        end
        if (best_found_reg) begin
            result_next.status           = pdsel_pkg::STATUS_OK;
            result_next.request_word     = {1'b0, index1, 8'd0, 1'b0,
                                            best_units_reg[pdsel_pkg::UNITS_W-1:1],
                                            best_units_reg};
            result_next.current_limit_ma = limit;
            result_next.voltage_mv       = best_voltage_reg;
        end else begin
            result_next.status           = pdsel_pkg::STATUS_NO_PDO;
            result_next.request_word     = '0;
            result_next.current_limit_ma = '0;
            result_next.voltage_mv       = '0;
        end
    end

    // Status to controller
    assign stat.last       = last_reg;
    assign stat.div_needed = best_found_reg && best_is_battery_reg && (best_voltage_reg != '0);
    assign stat.div_done   = (div_cnt_reg == pdsel_pkg::DIV_CNT_W'(pdsel_pkg::DIV_STEPS - 1));
    assign stat.out_free   = !out_valid_reg || m_ready;

    // Offer capture and power
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            units_reg   <= in_data.offer_word[9:0];
            mv_reg      <= pdsel_pkg::MV_W'(in_data.offer_word[19:10]) * pdsel_pkg::MV_PER_UNIT;
            ma_reg      <= pdsel_pkg::MA_W'(in_data.offer_word[9:0]) * pdsel_pkg::MA_PER_UNIT;
            battery_reg <= (in_data.offer_word[31:30] == pdsel_pkg::TYPE_BATTERY);
        end
        if (cmd.mult) begin
            power_reg <= battery_reg ? batt_power : prod;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg <= 1'b0;
        end else if (cmd.load) begin
            last_reg <= in_data.last_offer;
        end
    end

    // Voltage cap register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= pdsel_pkg::CAP_RESET;
        end else if (cfg_we) begin
            cap_reg <= cfg_wdata;
        end
    end

    // Best offer tracking, cleared once the result is issued
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.finish) begin
            offer_count_reg     <= '0;
            best_position_reg   <= '0;
            best_found_reg      <= 1'b0;
            best_power_reg      <= '0;
            best_voltage_reg    <= '0;
            best_units_reg      <= '0;
            best_is_battery_reg <= 1'b0;
        end else if (cmd.compare) begin
            if (offer_count_reg < MAX_CNT) begin
                offer_count_reg <= offer_count_reg + 3'd1;
            end
            if (take) begin
                best_found_reg      <= 1'b1;
                best_position_reg   <= offer_count_reg;
                best_power_reg      <= power_reg;
                best_voltage_reg    <= mv_reg;
                best_units_reg      <= units_reg;
                best_is_battery_reg <= battery_reg;
            end
        end
    end

    // Serial divider, one quotient bit per cycle
    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            quo_reg     <= best_power_reg;
            rem_reg     <= '0;
            div_cnt_reg <= '0;
        end else if (cmd.div_step) begin
            if (trial[pdsel_pkg::MV_W]) begin
                rem_reg <= shifted[pdsel_pkg::MV_W-1:0];
                quo_reg <= {quo_reg[pdsel_pkg::POWER_W-2:0], 1'b0};
            end else begin
                rem_reg <= trial[pdsel_pkg::MV_W-1:0];
                quo_reg <= {quo_reg[pdsel_pkg::POWER_W-2:0], 1'b1};
            end
            div_cnt_reg <= div_cnt_reg + 5'd1;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            out_reg <= result_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // Checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        offer_count_reg <= MAX_CNT)
        else $error("offer count beyond limit");

    a_clear_after_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> (offer_count_reg == '0) && !best_found_reg)
        else $error("list state not cleared after result");

    a_none_zero_power: assert property (@(posedge aclk) disable iff (!aresetn)
        !best_found_reg |-> (best_power_reg == '0))
        else $error("power held with no offer kept");

    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> (rem_reg < best_voltage_reg))
        else $error("divider remainder out of range");

    a_finish_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> stat.out_free)
        else $error("result overwritten before transfer");

endmodule

// ===== hdl/pdsel_ctrl.sv =====
// Controller: sequences capture, power, compare per offer, then divide and result issue.
module pdsel_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  pdsel_pkg::status_t  stat,
    output pdsel_pkg::cmd_t     cmd
);

    pdsel_pkg::state_t state_reg;
    pdsel_pkg::state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pdsel_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            pdsel_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = pdsel_pkg::ST_MULT;
                end
            end
            pdsel_pkg::ST_MULT: begin
                cmd.mult   = 1'b1;
                state_next = pdsel_pkg::ST_CMP;
            end
            pdsel_pkg::ST_CMP: begin
                cmd.compare = 1'b1;
                state_next  = stat.last ? pdsel_pkg::ST_DIV_SET : pdsel_pkg::ST_IDLE;
            end
            pdsel_pkg::ST_DIV_SET: begin
                cmd.div_init = 1'b1;
                state_next   = stat.div_needed ? pdsel_pkg::ST_DIV : pdsel_pkg::ST_FINISH;
            end
            pdsel_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_done) begin
                    state_next = pdsel_pkg::ST_FINISH;
                end
            end
            pdsel_pkg::ST_FINISH: begin
                if (stat.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = pdsel_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pdsel_pkg::ST_IDLE;
            end
        endcase
    end

    // Checks
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == pdsel_pkg::ST_MULT))
        else $error("transfer not followed by power stage");

    a_div_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pdsel_pkg::ST_DIV && stat.div_done) |=> (state_reg == pdsel_pkg::ST_FINISH))
        else $error("divider completion missed");

    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(cmd))
        else $error("more than one datapath command");

endmodule

// ===== hdl/pd_source_offer_selector.sv =====
// Top level of the USB PD source offer selector.
//
//  Channel  Ports                      Direction  Carries
//  input    s_valid s_ready s_data     in         offer word and last mark
//  result   m_valid m_ready m_data     out        status, request, limit, voltage
//  config   cfg_we cfg_wdata           in         voltage cap in mV
//
// Each offer passes capture, power product and compare before the next is taken.
// The last offer adds a divider setup step and a finish step, and on a battery best offer
// the bit-serial divider, which produces one quotient bit per cycle.
// Reset (aresetn low, synchronous) clears the list state and sets the cap to 65535 mV.
// A result waits in its output register; a stalled result holds only the finish step.
module pd_source_offer_selector #(
    parameter int MAX_OFFERS = 7
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  pdsel_pkg::offer_in_t s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output pdsel_pkg::result_t   m_data,
    input  logic                 cfg_we,
    input  logic [15:0]          cfg_wdata
);

    pdsel_pkg::cmd_t    cmd;
    pdsel_pkg::status_t stat;

    // Sequencer
    pdsel_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Arithmetic and storage
    pdsel_datapath #(
        .MAX_OFFERS (MAX_OFFERS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (s_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
